// File: hw/rtl/u8sd_pkg.sv
`default_nettype none

package u8sd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned LenW   = 3;
  localparam int unsigned PendW  = 2;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;
  localparam logic [ByteW-1:0] AsciiMask = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Tag  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Tag  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Tag  = 8'hF0;
  localparam logic [ByteW-1:0] PayMask6  = 8'h3F;
  localparam logic [ByteW-1:0] PayMask5  = 8'h1F;
  localparam logic [ByteW-1:0] PayMask4  = 8'h0F;
  localparam logic [ByteW-1:0] PayMask3  = 8'h07;

  typedef struct packed {
    logic [PendW-1:0] pending_count;
    logic [LenW-1:0]  consumed_count;
    logic [CpW-1:0]   partial_value;
  } u8sd_state_t;

  typedef struct packed {
    logic            char_valid;
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] seq_length;
    logic [LenW-1:0] bytes_dropped;
    logic            string_end;
  } u8sd_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/utf8_stream_decoder_unit.sv
// pipeline: an accepted word is held in the input register and its decoded
//   result in the result register; throughput: one word per cycle when the
//   output is not stalled, set by the combinational decode stage between them
// reset: rst_ni asynchronous active low; clears both valid flags and the
//   open-sequence state, so the first word is decoded as a lead
`default_nettype none

module utf8_stream_decoder_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [u8sd_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic                          s_axis_tlast,  // string_last
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [20:0] code_point, [23:21] seq_length, [26:24] bytes_dropped, [31:27] zero
  output logic [u8sd_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic                               m_axis_tuser,  // char_valid
  output logic                               m_axis_tlast   // string_end
);

  logic                         in_valid_q, in_valid_d;
  logic [u8sd_pkg::ByteW-1:0]   in_byte_q;
  logic                         in_last_q;
  logic                         out_valid_q, out_valid_d;
  u8sd_pkg::u8sd_result_t       out_res_q;
  u8sd_pkg::u8sd_state_t        state_q, state_d;
  u8sd_pkg::u8sd_result_t       dec_res;
  logic                         out_free;
  logic                         fire;
  logic                         in_acc;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  u8sd_decode u_decode (
    .data_byte_i   (in_byte_q),
    .string_last_i (in_last_q),
    .state_i       (state_q),
    .state_o       (state_d),
    .result_o      (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= s_axis_tdata[u8sd_pkg::ByteW-1:0];
      in_last_q <= s_axis_tlast;
    end
    if (fire) begin
      out_res_q <= dec_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.char_valid;
  assign m_axis_tlast  = out_res_q.string_end;
  assign m_axis_tdata  = {5'b0, out_res_q.bytes_dropped, out_res_q.seq_length,
                          out_res_q.code_point};

endmodule

`default_nettype wire

// File: hw/rtl/u8sd_decode.sv
`default_nettype none

module u8sd_decode (
  input  wire logic [u8sd_pkg::ByteW-1:0] data_byte_i,
  input  wire logic                       string_last_i,
  input  wire u8sd_pkg::u8sd_state_t      state_i,
  output u8sd_pkg::u8sd_state_t           state_o,
  output u8sd_pkg::u8sd_result_t          result_o
);

  always_comb begin
    logic                          as_lead;
    logic [u8sd_pkg::PendW-1:0]    pend_dec;
    u8sd_pkg::u8sd_state_t         nxt;
    u8sd_pkg::u8sd_result_t        res;

    nxt      = state_i;
    res      = '0;
    as_lead  = 1'b1;
    pend_dec = state_i.pending_count - u8sd_pkg::PendW'(1);

    // open sequence: continue or break
    if (state_i.pending_count != '0) begin
      if ((data_byte_i & u8sd_pkg::ContMask) == u8sd_pkg::ContTag) begin
        as_lead = 1'b0;
        nxt.partial_value  = {state_i.partial_value[u8sd_pkg::CpW-7:0], data_byte_i[5:0]};
        nxt.consumed_count = state_i.consumed_count + u8sd_pkg::LenW'(1);
        nxt.pending_count  = pend_dec;
        if (pend_dec == '0) begin
          res.char_valid = 1'b1;
          res.code_point = nxt.partial_value;
          res.seq_length = nxt.consumed_count;
          nxt = '0;
        end
      end else begin
        res.bytes_dropped = state_i.consumed_count;
        nxt = '0;
      end
    end

    if (as_lead) begin
      priority if ((data_byte_i & u8sd_pkg::AsciiMask) == '0) begin
        res.char_valid = 1'b1;
        res.code_point = u8sd_pkg::CpW'(data_byte_i);
        res.seq_length = u8sd_pkg::LenW'(1);
      end else if ((data_byte_i & u8sd_pkg::Lead2Mask) == u8sd_pkg::Lead2Tag) begin
        nxt.pending_count  = u8sd_pkg::PendW'(1);
        nxt.consumed_count = u8sd_pkg::LenW'(1);
        nxt.partial_value  = u8sd_pkg::CpW'(data_byte_i & u8sd_pkg::PayMask5);
      end else if ((data_byte_i & u8sd_pkg::Lead3Mask) == u8sd_pkg::Lead3Tag) begin
        nxt.pending_count  = u8sd_pkg::PendW'(2);
        nxt.consumed_count = u8sd_pkg::LenW'(1);
        nxt.partial_value  = u8sd_pkg::CpW'(data_byte_i & u8sd_pkg::PayMask4);
      end else if ((data_byte_i & u8sd_pkg::Lead4Mask) == u8sd_pkg::Lead4Tag) begin
        nxt.pending_count  = u8sd_pkg::PendW'(3);
        nxt.consumed_count = u8sd_pkg::LenW'(1);
        nxt.partial_value  = u8sd_pkg::CpW'(data_byte_i & u8sd_pkg::PayMask3);
      end else begin
        res.bytes_dropped = res.bytes_dropped + u8sd_pkg::LenW'(1);
      end
    end

    // truncated sequence at string end
    if (string_last_i && (nxt.pending_count != '0)) begin
      res.bytes_dropped = res.bytes_dropped + nxt.consumed_count;
      nxt = '0;
    end

    res.string_end = string_last_i;
    state_o  = nxt;
    result_o = res;
  end

endmodule

`default_nettype wire

// File: hw/rtl/u8sd_checker.sv
`default_nettype none

module u8sd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // stalled result word must stay
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // no code point without a completed char
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:0] == 24'd0)
    else $error("code point or length set without char_valid");

  // completed char carries a length of 1 to 4
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[23:21] != 3'd0 && m_axis_tdata[23:21] <= 3'd4)
    else $error("bad sequence length");

  // single-byte char carries a 7-bit code point
  a_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && m_axis_tdata[23:21] == 3'd1 |->
      m_axis_tdata[20:7] == 14'd0)
    else $error("single-byte char out of range");

  a_drop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[26:24] <= 3'd4 && m_axis_tdata[31:27] == 5'd0)
    else $error("drop count or padding out of range");

endmodule

bind utf8_stream_decoder_unit u8sd_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandBytes  = 1900;
  localparam int unsigned QuietFrom  = 600;
  localparam int unsigned QuietTo    = 1400;

  typedef struct packed {
    logic [u8sd_pkg::ByteW-1:0] data_byte;
    logic                       string_last;
  } byte_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [u8sd_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [u8sd_pkg::OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  byte_word_t             byte_q[$];
  u8sd_pkg::u8sd_result_t char_exp_q[$];
  int unsigned            cycle_cnt = 0;
  int unsigned            err_cnt = 0;

  // decoder state mirror
  logic [u8sd_pkg::PendW-1:0] pend_cnt = '0;
  logic [u8sd_pkg::LenW-1:0]  took_cnt = '0;
  logic [u8sd_pkg::CpW-1:0]   acc_val = '0;

  utf8_stream_decoder_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic take_break();
    if (cycle_cnt >= QuietFrom && cycle_cnt < QuietTo) begin
      return 1'b0;
    end
    return $urandom_range(99) < 21;
  endfunction

  function automatic u8sd_pkg::u8sd_result_t decode_byte(
      input logic [u8sd_pkg::ByteW-1:0] b, input logic last);
    u8sd_pkg::u8sd_result_t res;
    logic                   as_lead;
    res = '0;
    as_lead = 1'b1;
    if (pend_cnt != 0) begin
      if ((b & u8sd_pkg::ContMask) == u8sd_pkg::ContTag) begin
        as_lead = 1'b0;
        acc_val = {acc_val[u8sd_pkg::CpW-7:0], b[5:0]};
        took_cnt = took_cnt + 1'b1;
        pend_cnt = pend_cnt - 1'b1;
        if (pend_cnt == 0) begin
          res.char_valid = 1'b1;
          res.code_point = acc_val;
          res.seq_length = took_cnt;
          took_cnt = '0;
          acc_val = '0;
        end
      end else begin
        // broken sequence, open bytes are lost
        res.bytes_dropped = took_cnt;
        pend_cnt = '0;
        took_cnt = '0;
        acc_val = '0;
      end
    end
    if (as_lead) begin
      if ((b & u8sd_pkg::AsciiMask) == 0) begin
        res.char_valid = 1'b1;
        res.code_point = u8sd_pkg::CpW'(b);
        res.seq_length = 3'd1;
      end else if ((b & u8sd_pkg::Lead2Mask) == u8sd_pkg::Lead2Tag) begin
        pend_cnt = 2'd1;
        took_cnt = 3'd1;
        acc_val = u8sd_pkg::CpW'(b & u8sd_pkg::PayMask5);
      end else if ((b & u8sd_pkg::Lead3Mask) == u8sd_pkg::Lead3Tag) begin
        pend_cnt = 2'd2;
        took_cnt = 3'd1;
        acc_val = u8sd_pkg::CpW'(b & u8sd_pkg::PayMask4);
      end else if ((b & u8sd_pkg::Lead4Mask) == u8sd_pkg::Lead4Tag) begin
        pend_cnt = 2'd3;
        took_cnt = 3'd1;
        acc_val = u8sd_pkg::CpW'(b & u8sd_pkg::PayMask3);
      end else begin
        res.bytes_dropped = res.bytes_dropped + 1'b1;
      end
    end
    if (last && pend_cnt != 0) begin
      res.bytes_dropped = res.bytes_dropped + took_cnt;
      pend_cnt = '0;
      took_cnt = '0;
      acc_val = '0;
    end
    res.string_end = last;
    return res;
  endfunction

  // input side
  always @(posedge clk_i) begin
    byte_word_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        char_exp_q.push_back(decode_byte(s_axis_tdata[u8sd_pkg::ByteW-1:0], s_axis_tlast));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_q.size() != 0 && !take_break()) begin
          nxt = byte_q.pop_front();
          s_axis_tdata <= nxt.data_byte;
          s_axis_tlast <= nxt.string_last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i) begin
    u8sd_pkg::u8sd_result_t got;
    u8sd_pkg::u8sd_result_t want;
    m_axis_tready <= !take_break();
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.char_valid    = m_axis_tuser;
      got.code_point    = m_axis_tdata[u8sd_pkg::CpW-1:0];
      got.seq_length    = m_axis_tdata[u8sd_pkg::CpW+u8sd_pkg::LenW-1:u8sd_pkg::CpW];
      got.bytes_dropped =
          m_axis_tdata[u8sd_pkg::CpW+2*u8sd_pkg::LenW-1:u8sd_pkg::CpW+u8sd_pkg::LenW];
      got.string_end    = m_axis_tlast;
      if (char_exp_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected word valid=%0b cp=%06h len=%0d drop=%0d end=%0b", $time,
                 got.char_valid, got.code_point, got.seq_length, got.bytes_dropped,
                 got.string_end);
      end else begin
        want = char_exp_q.pop_front();
        if (got !== want ||
            m_axis_tdata[u8sd_pkg::OutDataW-1:u8sd_pkg::CpW+2*u8sd_pkg::LenW] !== '0) begin
          err_cnt++;
          $display("%0t: expected valid=%0b cp=%06h len=%0d drop=%0d end=%0b", $time,
                   want.char_valid, want.code_point, want.seq_length, want.bytes_dropped,
                   want.string_end);
          $display("%0t: actual   valid=%0b cp=%06h len=%0d drop=%0d end=%0b pad=%02h",
                   $time, got.char_valid, got.code_point, got.seq_length,
                   got.bytes_dropped, got.string_end,
                   m_axis_tdata[u8sd_pkg::OutDataW-1:u8sd_pkg::CpW+2*u8sd_pkg::LenW]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [u8sd_pkg::ByteW-1:0] str_q[$];
    int unsigned                n_chars;
    int unsigned                seq_len;
    int unsigned                n_cont;
    int unsigned                added;
    int unsigned                pick;

    // directed strings
    byte_q.push_back('{8'h00, 1'b0});
    byte_q.push_back('{8'h7F, 1'b0});
    byte_q.push_back('{8'hC2, 1'b0});
    byte_q.push_back('{8'hA9, 1'b0});
    // largest 21-bit value
    byte_q.push_back('{8'hF7, 1'b0});
    byte_q.push_back('{8'hBF, 1'b0});
    byte_q.push_back('{8'hBF, 1'b0});
    byte_q.push_back('{8'hBF, 1'b1});
    // stray continuation, invalid lead
    byte_q.push_back('{8'h80, 1'b0});
    byte_q.push_back('{8'hF8, 1'b0});
    // broken sequence then ascii
    byte_q.push_back('{8'hE2, 1'b0});
    byte_q.push_back('{8'h41, 1'b0});
    // broken sequence plus truncation in one step
    byte_q.push_back('{8'hF0, 1'b0});
    byte_q.push_back('{8'h90, 1'b0});
    byte_q.push_back('{8'h80, 1'b0});
    byte_q.push_back('{8'hE2, 1'b1});
    // broken sequence by invalid lead
    byte_q.push_back('{8'hE2, 1'b0});
    byte_q.push_back('{8'hFF, 1'b0});
    // truncated at string end
    byte_q.push_back('{8'hC3, 1'b1});
    // overlong zero
    byte_q.push_back('{8'hE0, 1'b0});
    byte_q.push_back('{8'h80, 1'b0});
    byte_q.push_back('{8'h80, 1'b1});

    // random strings, mostly well-formed
    added = 0;
    while (added < RandBytes) begin
      str_q.delete();
      n_chars = $urandom_range(1, 12);
      repeat (n_chars) begin
        pick = $urandom_range(99);
        seq_len = $urandom_range(1, 4);
        if (pick < 10) begin
          str_q.push_back(u8sd_pkg::ByteW'($urandom_range(255)));
        end else begin
          case (seq_len)
            1: str_q.push_back(u8sd_pkg::ByteW'($urandom_range(127)));
            2: str_q.push_back(u8sd_pkg::Lead2Tag | u8sd_pkg::ByteW'($urandom_range(31)));
            3: str_q.push_back(u8sd_pkg::Lead3Tag | u8sd_pkg::ByteW'($urandom_range(15)));
            default: str_q.push_back(u8sd_pkg::Lead4Tag | u8sd_pkg::ByteW'($urandom_range(7)));
          endcase
          n_cont = seq_len - 1;
          if (pick < 20 && seq_len > 1) begin
            n_cont = $urandom_range(seq_len - 2);
          end
          repeat (n_cont) begin
            str_q.push_back(u8sd_pkg::ContTag | u8sd_pkg::ByteW'($urandom_range(63)));
          end
        end
      end
      for (int i = 0; i < str_q.size(); i++) begin
        byte_q.push_back('{str_q[i], i == str_q.size() - 1});
      end
      added += str_q.size();
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (char_exp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
